// ===== rtl/socd_pkg.sv =====
`timescale 1ns / 1ps

package socd_pkg;

  localparam int unsigned KEY_W     = 8;
  localparam int unsigned MAX_SLOTS = 8;
  localparam int unsigned GRP_ID_W  = 3;

  localparam logic [KEY_W-1:0] KEY_NONE = '0;

  localparam logic [1:0] CFG_SLOT_KEYS   = 2'd0;
  localparam logic [1:0] CFG_SLOT_GROUPS = 2'd1;
  localparam logic [1:0] CFG_BYPASS      = 2'd2;

  typedef struct packed {
    logic [KEY_W*MAX_SLOTS-1:0]    slot_key_codes;
    logic [GRP_ID_W*MAX_SLOTS-1:0] slot_group_ids;
    logic                          bypass;
  } cfg_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_code;
    logic             pressed;
    logic             injected;
  } key_evt_t;

  typedef struct packed {
    logic [KEY_W-1:0] out_key;
    logic             out_pressed;
    logic             passed_through;
    logic             last_of_run;
  } result_t;

endpackage

// ===== rtl/socd_engine.sv =====
`timescale 1ns / 1ps

module socd_engine #(
  parameter int unsigned NUM_SLOTS  = 8,
  parameter int unsigned NUM_GROUPS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  socd_pkg::cfg_t    cfg_i,
  input  socd_pkg::key_evt_t evt_i,
  output socd_pkg::result_t res_o [2],
  output logic [1:0]        res_cnt_o
);

  localparam int unsigned SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned GRP_W  = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

  logic [NUM_SLOTS-1:0]         held_q, held_d;
  logic [socd_pkg::KEY_W-1:0]   act_q  [NUM_GROUPS];
  logic [socd_pkg::KEY_W-1:0]   prev_q [NUM_GROUPS];
  logic [socd_pkg::KEY_W-1:0]   act_d, prev_d;

  logic                          found, hit, held;
  logic [SLOT_W-1:0]             slot;
  logic [socd_pkg::GRP_ID_W-1:0] grp_raw;
  logic [GRP_W-1:0]              grp;
  logic [socd_pkg::KEY_W-1:0]    key, act, prev;

  assign key = evt_i.key_code;

  // lowest matching used slot
  always_comb begin
    found   = 1'b0;
    slot    = '0;
    grp_raw = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!found && cfg_i.slot_key_codes[socd_pkg::KEY_W*i +: socd_pkg::KEY_W] != socd_pkg::KEY_NONE
          && cfg_i.slot_key_codes[socd_pkg::KEY_W*i +: socd_pkg::KEY_W] == key) begin
        found   = 1'b1;
        slot    = SLOT_W'(i);
        grp_raw = cfg_i.slot_group_ids[socd_pkg::GRP_ID_W*i +: socd_pkg::GRP_ID_W];
      end
    end
  end

  // group number wraps into range
  always_comb begin
    grp = '0;
    for (int k = 0; k < (1 << socd_pkg::GRP_ID_W); k++) begin
      if (grp_raw == socd_pkg::GRP_ID_W'(k)) begin
        grp = GRP_W'(k % NUM_GROUPS);
      end
    end
  end

  assign hit  = found && !cfg_i.bypass && !evt_i.injected && key != socd_pkg::KEY_NONE;
  assign held = held_q[slot];
  assign act  = act_q[grp];
  assign prev = prev_q[grp];

  always_comb begin
    held_d    = held_q;
    act_d     = act;
    prev_d    = prev;
    res_cnt_o = 2'd0;
    res_o[0]  = '{out_key: key, out_pressed: evt_i.pressed, passed_through: 1'b1,
                  last_of_run: 1'b1};
    res_o[1]  = '{out_key: key, out_pressed: 1'b0, passed_through: 1'b0, last_of_run: 1'b1};
    if (!hit) begin
      res_cnt_o = 2'd1;
    end else if (evt_i.pressed) begin
      if (!held) begin
        held_d[slot] = 1'b1;
        act_d        = key;
        res_o[0]     = '{out_key: key, out_pressed: 1'b1, passed_through: 1'b0,
                         last_of_run: 1'b1};
        res_cnt_o    = 2'd1;
        if (act != socd_pkg::KEY_NONE && act != key) begin
          prev_d               = act;
          res_o[0].last_of_run = 1'b0;
          res_o[1]             = '{out_key: act, out_pressed: 1'b0, passed_through: 1'b0,
                                   last_of_run: 1'b1};
          res_cnt_o            = 2'd2;
        end
      end
    end else begin
      if (!held) begin
        if (prev == key) begin
          prev_d = socd_pkg::KEY_NONE;
        end
      end else begin
        held_d[slot] = 1'b0;
        prev_d       = socd_pkg::KEY_NONE;
        res_o[0]     = '{out_key: key, out_pressed: 1'b0, passed_through: 1'b0,
                         last_of_run: 1'b1};
        res_cnt_o    = 2'd1;
        if (act == key && prev != socd_pkg::KEY_NONE) begin
          act_d                = prev;
          res_o[0].last_of_run = 1'b0;
          res_o[1]             = '{out_key: prev, out_pressed: 1'b1, passed_through: 1'b0,
                                   last_of_run: 1'b1};
          res_cnt_o            = 2'd2;
        end else if (act == key) begin
          act_d = socd_pkg::KEY_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        act_q[g]  <= socd_pkg::KEY_NONE;
        prev_q[g] <= socd_pkg::KEY_NONE;
      end
    end else if (step_i && hit) begin
      held_q      <= held_d;
      act_q[grp]  <= act_d;
      prev_q[grp] <= prev_d;
    end
  end

  a_pass_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hit |-> res_cnt_o == 2'd1 && res_o[0].passed_through)
    else $error("pass-through must give one result");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_o == 2'd2 |-> !res_o[0].last_of_run && res_o[1].last_of_run &&
                          res_o[0].out_pressed != res_o[1].out_pressed)
    else $error("two-result run malformed");

  a_active_diff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && hit && res_cnt_o == 2'd2 |=> act_q[$past(grp)] != prev_q[$past(grp)])
    else $error("active and remembered key equal after swap");

endmodule

// ===== rtl/socd_last_input_key_resolver.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake                  Payload
// in       sink       in_valid_i / in_stall_o    key_code_i, pressed_i, injected_i
// out      source     out_valid_o / out_stall_i  out_key_o, out_pressed_o,
//                                                passed_through_o, last_of_run_o
// cfg      sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// An event is registered on acceptance and resolved into a two-entry result queue
// once that queue has room; the queue head register offers each result beat.
// One event per cycle while each gives at most one result and out_stall_i is low; a
// two-result event fills the queue, so the input stalls until its last beat is taken.
// Reset clears the configuration and all key state; cfg_ready_o is always high.

module socd_last_input_key_resolver #(
  parameter int unsigned NUM_SLOTS  = 8,
  parameter int unsigned NUM_GROUPS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  key_code_i,
  input  logic        pressed_i,
  input  logic        injected_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_key_o,
  output logic        out_pressed_o,
  output logic        passed_through_o,
  output logic        last_of_run_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  socd_pkg::cfg_t     cfg_q;
  socd_pkg::key_evt_t evt_q;
  logic               evt_vld_q, evt_vld_d;
  socd_pkg::result_t  res [2];
  logic [1:0]         res_cnt;
  socd_pkg::result_t  out_q [2];
  logic [1:0]         out_cnt_q, out_cnt_d;
  logic               in_acc, pop, fire;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        socd_pkg::CFG_SLOT_KEYS:   cfg_q.slot_key_codes <= cfg_data_i;
        socd_pkg::CFG_SLOT_GROUPS: cfg_q.slot_group_ids <= cfg_data_i[23:0];
        socd_pkg::CFG_BYPASS:      cfg_q.bypass         <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign pop        = out_valid_o && !out_stall_i;
  assign fire       = evt_vld_q && (out_cnt_q == 2'd0 || (out_cnt_q == 2'd1 && pop));
  assign in_stall_o = evt_vld_q && !fire;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    evt_vld_d = evt_vld_q;
    if (in_acc) begin
      evt_vld_d = 1'b1;
    end else if (fire) begin
      evt_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_cnt_d = out_cnt_q;
    if (fire) begin
      out_cnt_d = res_cnt;
    end else if (pop) begin
      out_cnt_d = out_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_vld_q <= 1'b0;
      out_cnt_q <= 2'd0;
    end else begin
      evt_vld_q <= evt_vld_d;
      out_cnt_q <= out_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      evt_q <= '{key_code: key_code_i, pressed: pressed_i, injected: injected_i};
    end
    if (fire) begin
      out_q[0] <= res[0];
      out_q[1] <= res[1];
    end else if (pop) begin
      out_q[0] <= out_q[1];
    end
  end

  socd_engine #(
    .NUM_SLOTS (NUM_SLOTS),
    .NUM_GROUPS(NUM_GROUPS)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (fire),
    .cfg_i    (cfg_q),
    .evt_i    (evt_q),
    .res_o    (res),
    .res_cnt_o(res_cnt)
  );

  assign out_valid_o      = out_cnt_q != 2'd0;
  assign out_key_o        = out_q[0].out_key;
  assign out_pressed_o    = out_q[0].out_pressed;
  assign passed_through_o = out_q[0].passed_through;
  assign last_of_run_o    = out_q[0].last_of_run;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_cnt_q != 2'd3)
    else $error("result queue overfilled");

  a_fire_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_cnt_q == $past(res_cnt))
    else $error("resolved beats not queued cleanly");

  a_pass_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && passed_through_o |-> last_of_run_o && out_cnt_q == 2'd1)
    else $error("pass-through beat not alone");

  a_head_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_cnt_q == 2'd2 |-> !out_q[0].last_of_run && out_q[1].last_of_run)
    else $error("queued pair out of order");

endmodule

// ===== tb/socd_key_resolution_checker.sv =====
`timescale 1ns / 1ps

module socd_key_resolution_checker #(
  parameter int unsigned NUM_SLOTS  = 8,
  parameter int unsigned NUM_GROUPS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [7:0]  key_code_i,
  input  logic        pressed_i,
  input  logic        injected_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [7:0]  out_key_o,
  input  logic        out_pressed_o,
  input  logic        passed_through_o,
  input  logic        last_of_run_o,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output int          mismatch_count_o,
  output int          pending_results_o,
  output int          results_checked_o,
  output int          double_events_o,
  output int          swallowed_events_o
);

  socd_pkg::cfg_t             settings;
  logic                       slot_held    [NUM_SLOTS];
  logic [socd_pkg::KEY_W-1:0] active_key   [NUM_GROUPS];
  logic [socd_pkg::KEY_W-1:0] previous_key [NUM_GROUPS];
  socd_pkg::result_t          expected_beats [$];

  task automatic report_mismatch(input string what);
    mismatch_count_o++;
    $display("[%0t] resolver mismatch: %s", $time, what);
  endtask

  function automatic void expect_beat(input logic [socd_pkg::KEY_W-1:0] key,
                                      input logic down, input logic pass,
                                      input logic last);
    socd_pkg::result_t r;
    r.out_key        = key;
    r.out_pressed    = down;
    r.passed_through = pass;
    r.last_of_run    = last;
    expected_beats.insert(expected_beats.size(), r);
  endfunction

  function automatic void resolve_key_event(input socd_pkg::key_evt_t ev);
    int                         slot;
    int                         g;
    logic [socd_pkg::KEY_W-1:0] code;
    slot = -1;
    if (!settings.bypass && !ev.injected && ev.key_code != socd_pkg::KEY_NONE) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        code = settings.slot_key_codes[socd_pkg::KEY_W*i +: socd_pkg::KEY_W];
        if (slot < 0 && code != socd_pkg::KEY_NONE && code == ev.key_code) slot = i;
      end
    end
    if (slot < 0) begin
      expect_beat(ev.key_code, ev.pressed, 1'b1, 1'b1);
      return;
    end
    g = int'(settings.slot_group_ids[socd_pkg::GRP_ID_W*slot +: socd_pkg::GRP_ID_W])
        % NUM_GROUPS;

    if (ev.pressed) begin
      if (slot_held[slot]) begin
        swallowed_events_o++;
        return;
      end
      slot_held[slot] = 1'b1;
      if (active_key[g] == socd_pkg::KEY_NONE || active_key[g] == ev.key_code) begin
        active_key[g] = ev.key_code;
        expect_beat(ev.key_code, 1'b1, 1'b0, 1'b1);
        return;
      end
      previous_key[g] = active_key[g];
      active_key[g]   = ev.key_code;
      expect_beat(ev.key_code, 1'b1, 1'b0, 1'b0);
      expect_beat(previous_key[g], 1'b0, 1'b0, 1'b1);
      double_events_o++;
      return;
    end

    if (!slot_held[slot]) begin
      if (previous_key[g] == ev.key_code) previous_key[g] = socd_pkg::KEY_NONE;
      swallowed_events_o++;
      return;
    end
    slot_held[slot] = 1'b0;
    if (active_key[g] == ev.key_code && previous_key[g] != socd_pkg::KEY_NONE) begin
      active_key[g]   = previous_key[g];
      previous_key[g] = socd_pkg::KEY_NONE;
      expect_beat(ev.key_code, 1'b0, 1'b0, 1'b0);
      expect_beat(active_key[g], 1'b1, 1'b0, 1'b1);
      double_events_o++;
      return;
    end
    previous_key[g] = socd_pkg::KEY_NONE;
    if (active_key[g] == ev.key_code) active_key[g] = socd_pkg::KEY_NONE;
    expect_beat(ev.key_code, 1'b0, 1'b0, 1'b1);
  endfunction

  task automatic check_result_beat();
    socd_pkg::result_t got;
    socd_pkg::result_t want;
    got.out_key        = out_key_o;
    got.out_pressed    = out_pressed_o;
    got.passed_through = passed_through_o;
    got.last_of_run    = last_of_run_o;
    results_checked_o++;
    if (expected_beats.size() == 0) begin
      report_mismatch($sformatf("unexpected beat key=%h down=%b pass=%b last=%b",
                                got.out_key, got.out_pressed, got.passed_through,
                                got.last_of_run));
      return;
    end
    want = expected_beats.pop_front();
    if (got.out_key !== want.out_key || got.out_pressed !== want.out_pressed ||
        got.passed_through !== want.passed_through ||
        got.last_of_run !== want.last_of_run) begin
      report_mismatch($sformatf("got key=%h down=%b pass=%b last=%b, exp %h %b %b %b",
                                got.out_key, got.out_pressed, got.passed_through,
                                got.last_of_run, want.out_key, want.out_pressed,
                                want.passed_through, want.last_of_run));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    socd_pkg::key_evt_t ev;
    if (!rst_ni) begin
      settings = '0;
      for (int i = 0; i < NUM_SLOTS; i++) slot_held[i] = 1'b0;
      for (int i = 0; i < NUM_GROUPS; i++) begin
        active_key[i]   = socd_pkg::KEY_NONE;
        previous_key[i] = socd_pkg::KEY_NONE;
      end
      expected_beats.delete();
      pending_results_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          socd_pkg::CFG_SLOT_KEYS:   settings.slot_key_codes = cfg_data_i;
          socd_pkg::CFG_SLOT_GROUPS: settings.slot_group_ids = cfg_data_i[23:0];
          socd_pkg::CFG_BYPASS:      settings.bypass = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) check_result_beat();
      if (in_valid_i && !in_stall_o) begin
        ev.key_code = key_code_i;
        ev.pressed  = pressed_i;
        ev.injected = injected_i;
        resolve_key_event(ev);
      end
      pending_results_o = expected_beats.size();
    end
  end

endmodule

// ===== tb/socd_last_input_key_resolver_test.sv =====
`timescale 1ns / 1ps

module socd_last_input_key_resolver_test;

  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned TIMEOUT_NS    = 2 * 400_000;
  localparam int unsigned NUM_PHASES    = 9;

  localparam logic [7:0] KEY_A     = 8'h41;
  localparam logic [7:0] KEY_D     = 8'h44;
  localparam logic [7:0] KEY_W     = 8'h57;
  localparam logic [7:0] KEY_S     = 8'h53;
  localparam logic [7:0] KEY_SHIFT = 8'h10;
  localparam logic [7:0] KEY_TOP   = 8'hFF;
  localparam logic [7:0] KEY_HIGH  = 8'h80;
  localparam logic [7:0] KEY_ODD   = 8'h7E;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  key_code_i  = '0;
  logic        pressed_i   = 1'b0;
  logic        injected_i  = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_key_o;
  logic        out_pressed_o;
  logic        passed_through_o;
  logic        last_of_run_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i  = '0;

  int mismatch_count;
  int pending_results;
  int results_checked;
  int double_events;
  int swallowed_events;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_off_req  = 1'b0;
  bit          hold_off_done = 1'b0;
  int          events_sent   = 0;
  int          settings_used = 0;
  logic [63:0] listed_codes  = '0;
  bit          key_down [256];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  socd_last_input_key_resolver DUT (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .key_code_i, .pressed_i, .injected_i,
    .out_valid_o, .out_stall_i, .out_key_o, .out_pressed_o, .passed_through_o,
    .last_of_run_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  socd_key_resolution_checker resolution_check (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .key_code_i, .pressed_i, .injected_i,
    .out_valid_o, .out_stall_i, .out_key_o, .out_pressed_o, .passed_through_o,
    .last_of_run_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .mismatch_count_o   (mismatch_count),
    .pending_results_o  (pending_results),
    .results_checked_o  (results_checked),
    .double_events_o    (double_events),
    .swallowed_events_o (swallowed_events)
  );

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results outstanding", pending_results);
    $display("*** FAILED ***");
    $finish;
  end

  // receiver: random stall, or one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic write_register(input logic [1:0] idx, input logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic apply_settings(input logic [63:0] codes, input logic [23:0] groups,
                                input logic byp);
    write_register(socd_pkg::CFG_SLOT_KEYS, codes);
    write_register(socd_pkg::CFG_SLOT_GROUPS, {$urandom(), 8'($urandom()), groups});
    write_register(socd_pkg::CFG_BYPASS, {$urandom(), 31'($urandom()), byp});
    cfg_valid_i <= 1'b0;
    listed_codes = codes;
    settings_used++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic send_key_event(input logic [7:0] key, input logic down, input logic inj);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    key_code_i <= key;
    pressed_i  <= down;
    injected_i <= inj;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    if (!inj) key_down[key] = down;
    events_sent++;
  endtask

  function automatic logic [7:0] pick_listed_key();
    logic [7:0] code;
    code = socd_pkg::KEY_NONE;
    for (int t = 0; t < 8 && code == socd_pkg::KEY_NONE; t++) begin
      code = listed_codes[8*$urandom_range(7) +: 8];
    end
    if (code == socd_pkg::KEY_NONE) code = 8'($urandom_range(255, 1));
    return code;
  endfunction

  function automatic logic [7:0] pool_key();
    case ($urandom_range(8))
      0:       return socd_pkg::KEY_NONE;
      1:       return KEY_A;
      2:       return KEY_D;
      3:       return KEY_W;
      4:       return KEY_S;
      5:       return KEY_SHIFT;
      6:       return KEY_TOP;
      7:       return KEY_HIGH;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic random_key_event();
    int         r;
    logic [7:0] key;
    logic       down;
    r = $urandom_range(99);
    if (r < 78) begin
      key  = pick_listed_key();
      down = ($urandom_range(99) < 85) ? !key_down[key] : 1'($urandom_range(1));
      send_key_event(key, down, 1'b0);
    end else if (r < 88) begin
      send_key_event(8'($urandom_range(255)), 1'($urandom_range(1)),
                     1'($urandom_range(1)));
    end else if (r < 94) begin
      send_key_event(pick_listed_key(), 1'($urandom_range(1)), 1'b1);
    end else begin
      key = $urandom_range(1) ? socd_pkg::KEY_NONE : KEY_SHIFT;
      send_key_event(key, 1'($urandom_range(1)), 1'b0);
    end
  endtask

  task automatic random_settings(input logic byp);
    logic [63:0] codes;
    logic [23:0] groups;
    for (int i = 0; i < 8; i++) begin
      codes[8*i +: 8]  = pool_key();
      groups[3*i +: 3] = ($urandom_range(3) == 0) ? 3'($urandom_range(7))
                                                  : 3'($urandom_range(2));
    end
    apply_settings(codes, groups, byp);
  endtask

  initial begin
    int n_events;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    apply_settings({KEY_HIGH, socd_pkg::KEY_NONE, KEY_TOP, KEY_A, KEY_S, KEY_W, KEY_D,
                    KEY_A},
                   {3'd7, 3'd2, 3'd7, 3'd3, 3'd5, 3'd5, 3'd0, 3'd0}, 1'b0);
    send_key_event(KEY_A, 1'b1, 1'b0);
    send_key_event(KEY_A, 1'b1, 1'b0);     // repeat press, swallowed
    send_key_event(KEY_D, 1'b1, 1'b0);     // D wins, A released
    send_key_event(KEY_D, 1'b0, 1'b0);     // A restored
    send_key_event(KEY_A, 1'b0, 1'b0);
    send_key_event(KEY_A, 1'b0, 1'b0);     // stray release
    send_key_event(KEY_W, 1'b1, 1'b0);
    send_key_event(KEY_S, 1'b1, 1'b0);
    send_key_event(KEY_W, 1'b0, 1'b0);
    send_key_event(KEY_S, 1'b0, 1'b0);
    send_key_event(KEY_TOP, 1'b1, 1'b0);
    send_key_event(KEY_HIGH, 1'b1, 1'b0);
    send_key_event(KEY_TOP, 1'b0, 1'b0);
    send_key_event(KEY_HIGH, 1'b0, 1'b0);
    send_key_event(KEY_SHIFT, 1'b1, 1'b0);
    send_key_event(KEY_SHIFT, 1'b0, 1'b0);
    send_key_event(socd_pkg::KEY_NONE, 1'b1, 1'b0);
    send_key_event(KEY_A, 1'b1, 1'b1);
    send_key_event(KEY_A, 1'b0, 1'b1);
    send_key_event(KEY_ODD, 1'b0, 1'b0);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p / 3)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 46;
        end
        1: begin
          send_idle_pct = 46;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (p)
        1:       apply_settings('1, '1, 1'b0);
        4:       apply_settings('0, '0, 1'b0);
        7:       random_settings(1'b1);
        default: random_settings(1'b0);
      endcase
      n_events = (p == 4 || p == 7) ? 40 : 165;
      if (p == 6) hold_off_req = 1'b1;
      repeat (n_events) random_key_event();
      drain();
    end

    $display("%0d key events under %0d settings, %0d result beats checked",
             events_sent, settings_used, results_checked);
    $display("%0d events gave two beats, %0d were swallowed",
             double_events, swallowed_events);
    if (pending_results != 0) begin
      $display("%0d expected results never arrived", pending_results);
    end
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== socd_last_input_key_resolver.f =====
rtl/socd_pkg.sv
rtl/socd_engine.sv
rtl/socd_last_input_key_resolver.sv
tb/socd_key_resolution_checker.sv
tb/socd_last_input_key_resolver_test.sv
